[design/first_fit_free_list_allocator_macros.svh]
// Assertion macros used by the allocator controller.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffa: assertion failed");
`define FFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffa: implication failed");
`else
`define FFA_ASSERT(lbl, clk, rst, prop)
`define FFA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

[design/ffa_pkg.sv]
`timescale 1ns / 1ps
package ffa_pkg;
   localparam int ARENA_CHUNKS  = 128;
   localparam int CHUNK_BYTES   = 16;
   localparam int CHUNK_SHIFT   = $clog2(CHUNK_BYTES);
   localparam int HEADER_CHUNKS = 1;
   localparam int HDR_AW        = $clog2(ARENA_CHUNKS);
   localparam int ID_W          = 16;
   localparam int SIZE_W        = 16;
   localparam int TOP_W         = $clog2(ARENA_CHUNKS + 1);
   localparam int BYTES_W       = 16;
   localparam int UNITS_W       = BYTES_W + 2 - CHUNK_SHIFT;
   localparam int CHECK_W       = SIZE_W + 2;
   localparam int ALLOC_ITERS   = 2 * (ARENA_CHUNKS + 2);
   localparam int REL_ITERS     = ARENA_CHUNKS + 2;
   localparam int ACNT_W        = $clog2(ALLOC_ITERS);
   localparam int RCNT_W        = $clog2(REL_ITERS);
   localparam int LIMIT_W       = 8;
   localparam int FIELD_W       = 8;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);
   localparam logic               REG_LIMIT   = 1'b0;
   localparam logic               REQ_ALLOC   = 1'b0;
   localparam logic               REQ_FREE    = 1'b1;

   typedef enum logic [2:0] {
      ST_ALLOC   = 3'd0,
      ST_FREED   = 3'd1,
      ST_NULL    = 3'd2,
      ST_LIMIT   = 3'd3,
      ST_BADSIZE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_A_PREV,
      S_A_SCAN,
      S_A_TAIL,
      S_A_DONE,
      S_A_REGROW,
      S_F_HDR,
      S_R_START,
      S_R_WALK,
      S_R_NBR,
      S_R_PRV,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic [ID_W-1:0]   nxt;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef struct packed {
      logic              en;
      logic [HDR_AW-1:0] addr;
   } hdr_rd_type;

   typedef struct packed {
      logic              nxt_we;
      logic              size_we;
      logic [HDR_AW-1:0] addr;
      hdr_type           data;
   } hdr_wr_type;

   function automatic logic in_arena(input logic [ID_W:0] id);
      return (id != '0) && (id <= (ID_W + 1)'(ARENA_CHUNKS));
   endfunction

   function automatic logic [HDR_AW-1:0] hdr_index(input logic [ID_W:0] id);
      logic [ID_W:0] idx;
      idx = id - (ID_W + 1)'(1);
      return idx[HDR_AW-1:0];
   endfunction
endpackage

[design/first_fit_free_list_allocator.sv]
`timescale 1ns / 1ps
// A free checks the address, reads the block header, then walks the free list (up to ARENA_CHUNKS + 2
// nodes) and merges neighbours. An allocation scans from the rover; a growth adds a release walk.
// One item at a time; the header memory, read once per list node, sets the pace.
// A result waits in the output register while the next item is taken in.
// Reset (synchronous): free list, arena and totals empty, all headers read as zero at once
// through per-field valid bits, limit_chunks back to 128; no clearing pass.
module first_fit_free_list_allocator
   import ffa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,    // alloc_bytes [15:0], free_addr [23:16]
   input  logic              req_tuser,    // req_type [0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,    // addr [7:0], free_chunks [15:8], claimed_chunks [23:16]
   output logic [2:0]        rsp_tuser,    // status [2:0]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   logic [LIMIT_W-1:0] limit_chunks;
   hdr_rd_type         rd;
   hdr_wr_type         wr;
   hdr_type            rd_data;

   ffa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .limit_chunks (limit_chunks)
   );

   ffa_hdr_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_data (rd_data)
   );

   ffa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .limit_chunks (limit_chunks),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rd           (rd),
      .wr           (wr),
      .rd_data      (rd_data)
   );
endmodule

[design/ffa_hdr_mem.sv]
`timescale 1ns / 1ps
module ffa_hdr_mem
   import ffa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  hdr_rd_type rd,
   input  hdr_wr_type wr,
   output hdr_type    rd_data
);
   logic [ID_W-1:0]         nxt_mem  [ARENA_CHUNKS];
   logic [SIZE_W-1:0]       size_mem [ARENA_CHUNKS];
   logic [ARENA_CHUNKS-1:0] nvld_ff;
   logic [ARENA_CHUNKS-1:0] svld_ff;
   logic [ID_W-1:0]         rd_nxt_ff;
   logic [SIZE_W-1:0]       rd_size_ff;
   logic                    rd_nv_ff;
   logic                    rd_sv_ff;

   // Each field keeps its own valid bit so that a header never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         nvld_ff <= '0;
         svld_ff <= '0;
      end else begin
         if (wr.nxt_we) begin
            nvld_ff[wr.addr] <= 1'b1;
         end
         if (wr.size_we) begin
            svld_ff[wr.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.nxt_we) begin
         nxt_mem[wr.addr] <= wr.data.nxt;
      end
      if (wr.size_we) begin
         size_mem[wr.addr] <= wr.data.size;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_nxt_ff  <= nxt_mem[rd.addr];
         rd_size_ff <= size_mem[rd.addr];
         rd_nv_ff   <= nvld_ff[rd.addr];
         rd_sv_ff   <= svld_ff[rd.addr];
      end
   end

   assign rd_data.nxt  = rd_nv_ff ? rd_nxt_ff : '0;
   assign rd_data.size = rd_sv_ff ? rd_size_ff : '0;
endmodule

[design/ffa_csr.sv]
`timescale 1ns / 1ps
module ffa_csr
   import ffa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready,
   output logic [LIMIT_W-1:0] limit_chunks
);
   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               sel_limit;

   assign sel_limit  = (csr_paddr[2] == REG_LIMIT);
   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_limit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata   = sel_limit ? CSR_DW'(limit_ff) : '0;
   assign limit_chunks = limit_ff;
endmodule

[design/ffa_ctrl.sv]
`timescale 1ns / 1ps
`include "first_fit_free_list_allocator_macros.svh"
module ffa_ctrl
   import ffa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] limit_chunks,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,   // alloc_bytes, free_addr
   input  logic               req_tuser,   // req_type
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // addr, free_chunks, claimed_chunks
   output logic [2:0]         rsp_tuser,   // status
   output hdr_rd_type         rd,
   output hdr_wr_type         wr,
   input  hdr_type            rd_data
);
   ctrl_state_type      state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [UNITS_W-1:0]  units_ff, units_in;
   logic [ID_W-1:0]     bp_ff, bp_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [ID_W-1:0]     prev_ff, prev_in;
   logic [ID_W-1:0]     p_ff, p_in;
   logic [ID_W:0]       tail_ff, tail_in;
   logic [ID_W-1:0]     n_ff, n_in;
   logic [SIZE_W-1:0]   psize_ff, psize_in;
   logic [SIZE_W-1:0]   bsize_ff, bsize_in;
   logic [SIZE_W-1:0]   bnsz_ff, bnsz_in;
   logic [ID_W-1:0]     bnext_ff, bnext_in;
   logic [ID_W-1:0]     rover_ff, rover_in;
   logic [ID_W-1:0]     sent_ff, sent_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic [SIZE_W-1:0]   free_ff, free_in;
   logic [ACNT_W-1:0]   acnt_ff, acnt_in;
   logic [RCNT_W-1:0]   rcnt_ff, rcnt_in;
   logic                grow_ff, grow_in;
   status_type          status_ff, status_in;
   logic [FIELD_W-1:0]  addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;

   logic [ID_W-1:0]     node_next;
   logic [SIZE_W-1:0]   node_size;
   logic [BYTES_W:0]    bytes_up;
   logic [UNITS_W-1:0]  units_req;
   logic [SIZE_W:0]     units_x;
   logic                fit, exact, at_rover, grow_ok, over, found;
   logic                hi_merge, lo_merge, bad_hdr, bp_ok, acnt_last, rcnt_last, rsp_free;
   logic [SIZE_W-1:0]   rest;
   logic [ID_W:0]       tail_sum;
   logic [UNITS_W:0]    grow_sum;
   logic [ID_W-1:0]     grow_id;
   logic [CHECK_W-1:0]  check_sum;
   logic                rd_go, nx_go, sz_go;
   logic [ID_W-1:0]     rd_id, nx_id, nx_val;
   logic [ID_W:0]       sz_id;
   logic [SIZE_W-1:0]   sz_val;

   // The sentinel lives in a register; headers outside the arena read as zero.
   assign node_next = (rid_ff == '0) ? sent_ff
                    : (in_arena({1'b0, rid_ff}) ? rd_data.nxt : '0);
   assign node_size = in_arena({1'b0, rid_ff}) ? rd_data.size : '0;

   assign bytes_up  = (BYTES_W + 1)'(req_tdata[BYTES_W-1:0]) + (BYTES_W + 1)'(CHUNK_BYTES - 1);
   assign units_req = UNITS_W'(bytes_up >> CHUNK_SHIFT) + UNITS_W'(HEADER_CHUNKS);
   assign units_x   = (SIZE_W + 1)'(units_ff);
   assign fit       = {1'b0, node_size} >= units_x;
   assign exact     = {1'b0, node_size} == units_x;
   assign at_rover  = (p_ff == rover_ff);
   assign rest      = node_size - SIZE_W'(units_ff);
   assign tail_sum  = {1'b0, p_ff} + (ID_W + 1)'(rest);
   assign grow_sum  = (UNITS_W + 1)'(top_ff) + (UNITS_W + 1)'(units_ff);
   assign grow_ok   = grow_sum <= (UNITS_W + 1)'(ARENA_CHUNKS);
   assign grow_id   = ID_W'(top_ff) + ID_W'(1);
   assign check_sum = CHECK_W'(units_ff) + CHECK_W'(top_ff) + CHECK_W'(free_ff);
   assign over      = check_sum > CHECK_W'(limit_chunks);
   assign found     = ((bp_ff > p_ff) && (bp_ff < node_next))
                   || ((p_ff >= node_next) && ((bp_ff > p_ff) || (bp_ff < node_next)));
   assign hi_merge  = ({1'b0, bp_ff} + {1'b0, bsize_ff}) == {1'b0, n_ff};
   assign lo_merge  = ({1'b0, p_ff} + {1'b0, psize_ff}) == {1'b0, bp_ff};
   assign bad_hdr   = (node_size == '0) || (node_size > SIZE_W'(top_ff));
   assign bp_ok     = in_arena({1'b0, bp_ff});
   assign acnt_last = (acnt_ff == ACNT_W'(ALLOC_ITERS - 1));
   assign rcnt_last = (rcnt_ff == RCNT_W'(REL_ITERS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (kind_ff == REQ_ALLOC) begin
               state_in = over ? S_RESP : S_A_PREV;
            end else if ((bp_ff == '0) || !bp_ok) begin
               state_in = S_RESP;
            end else begin
               state_in = S_F_HDR;
            end
         end
         S_A_PREV: state_in = S_A_SCAN;
         S_A_SCAN: begin
            priority if (fit) begin
               state_in = exact ? S_A_DONE : S_A_TAIL;
            end else if (at_rover) begin
               state_in = grow_ok ? S_R_START : S_RESP;
            end else if (acnt_last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_A_SCAN;
            end
         end
         S_A_TAIL:   state_in = S_A_DONE;
         S_A_DONE:   state_in = S_RESP;
         S_A_REGROW: state_in = acnt_last ? S_RESP : S_A_PREV;
         S_F_HDR:    state_in = bad_hdr ? S_RESP : S_R_START;
         S_R_START:  state_in = S_R_WALK;
         S_R_WALK: begin
            priority if (found) begin
               state_in = S_R_NBR;
            end else if (rcnt_last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_R_WALK;
            end
         end
         S_R_NBR: state_in = S_R_PRV;
         S_R_PRV: state_in = grow_ff ? S_A_REGROW : S_RESP;
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      kind_in       = kind_ff;
      units_in      = units_ff;
      bp_in         = bp_ff;
      rid_in        = rid_ff;
      prev_in       = prev_ff;
      p_in          = p_ff;
      tail_in       = tail_ff;
      n_in          = n_ff;
      psize_in      = psize_ff;
      bsize_in      = bsize_ff;
      bnsz_in       = bnsz_ff;
      bnext_in      = bnext_ff;
      rover_in      = rover_ff;
      sent_in       = sent_ff;
      top_in        = top_ff;
      free_in       = free_ff;
      acnt_in       = acnt_ff;
      rcnt_in       = rcnt_ff;
      grow_in       = grow_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rd_go  = 1'b0;
      rd_id  = '0;
      nx_go  = 1'b0;
      nx_id  = '0;
      nx_val = '0;
      sz_go  = 1'b0;
      sz_id  = '0;
      sz_val = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               units_in = units_req;
               bp_in    = ID_W'(req_tdata[23:16]);
               addr_in  = '0;
               acnt_in  = '0;
               grow_in  = 1'b0;
            end
         end
         S_CHECK: begin
            if (kind_ff == REQ_ALLOC) begin
               if (over) begin
                  status_in = ST_LIMIT;
               end else begin
                  prev_in = rover_ff;
                  rd_go   = 1'b1;
                  rd_id   = rover_ff;
               end
            end else if (bp_ff == '0) begin
               status_in = ST_NULL;
            end else if (!bp_ok) begin
               status_in = ST_BADSIZE;
            end else begin
               rd_go = 1'b1;
               rd_id = bp_ff;
            end
         end
         S_A_PREV: begin
            p_in  = node_next;
            rd_go = 1'b1;
            rd_id = node_next;
         end
         S_A_SCAN: begin
            priority if (fit && exact) begin
               nx_go   = 1'b1;
               nx_id   = prev_ff;
               nx_val  = node_next;
               addr_in = p_ff[FIELD_W-1:0];
            end else if (fit) begin
               // The block gives up its tail; the new header goes at the split point.
               sz_go   = 1'b1;
               sz_id   = {1'b0, p_ff};
               sz_val  = rest;
               tail_in = tail_sum;
               addr_in = tail_sum[FIELD_W-1:0];
            end else if (at_rover) begin
               if (grow_ok) begin
                  sz_go    = 1'b1;
                  sz_id    = {1'b0, grow_id};
                  sz_val   = SIZE_W'(units_ff);
                  top_in   = grow_sum[TOP_W-1:0];
                  bp_in    = grow_id;
                  bsize_in = SIZE_W'(units_ff);
                  grow_in  = 1'b1;
               end else begin
                  status_in = ST_LIMIT;
               end
            end else if (acnt_last) begin
               status_in = ST_LIMIT;
            end else begin
               prev_in = p_ff;
               p_in    = node_next;
               acnt_in = acnt_ff + ACNT_W'(1);
               rd_go   = 1'b1;
               rd_id   = node_next;
            end
         end
         S_A_TAIL: begin
            sz_go  = 1'b1;
            sz_id  = tail_ff;
            sz_val = SIZE_W'(units_ff);
         end
         S_A_DONE: begin
            rover_in  = prev_ff;
            free_in   = free_ff - SIZE_W'(units_ff);
            status_in = ST_ALLOC;
         end
         S_A_REGROW: begin
            if (acnt_last) begin
               status_in = ST_LIMIT;
            end else begin
               acnt_in = acnt_ff + ACNT_W'(1);
               prev_in = rover_ff;
               rd_go   = 1'b1;
               rd_id   = rover_ff;
            end
         end
         S_F_HDR: begin
            if (bad_hdr) begin
               status_in = ST_BADSIZE;
            end else begin
               bsize_in = node_size;
            end
         end
         S_R_START: begin
            p_in    = rover_ff;
            rcnt_in = '0;
            rd_go   = 1'b1;
            rd_id   = rover_ff;
         end
         S_R_WALK: begin
            priority if (found) begin
               n_in     = node_next;
               psize_in = node_size;
               rd_go    = 1'b1;
               rd_id    = node_next;
            end else if (rcnt_last) begin
               status_in = grow_ff ? ST_LIMIT : ST_BADSIZE;
            end else begin
               p_in    = node_next;
               rcnt_in = rcnt_ff + RCNT_W'(1);
               rd_go   = 1'b1;
               rd_id   = node_next;
            end
         end
         S_R_NBR: begin
            nx_go = 1'b1;
            nx_id = bp_ff;
            if (hi_merge) begin
               bnsz_in  = bsize_ff + node_size;
               bnext_in = node_next;
               nx_val   = node_next;
               sz_go    = 1'b1;
               sz_id    = {1'b0, bp_ff};
               sz_val   = bsize_ff + node_size;
            end else begin
               bnsz_in  = bsize_ff;
               bnext_in = n_ff;
               nx_val   = n_ff;
            end
         end
         S_R_PRV: begin
            nx_go = 1'b1;
            nx_id = p_ff;
            if (lo_merge) begin
               nx_val = bnext_ff;
               sz_go  = 1'b1;
               sz_id  = {1'b0, p_ff};
               sz_val = psize_ff + bnsz_ff;
            end else begin
               nx_val = bp_ff;
            end
            rover_in = p_ff;
            free_in  = free_ff + bsize_ff;
            if (!grow_ff) begin
               status_in = ST_FREED;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {FIELD_W'(top_ff), free_ff[FIELD_W-1:0], addr_ff};
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase

      rd = '0;
      if (rd_go) begin
         rid_in  = rd_id;
         rd.en   = in_arena({1'b0, rd_id});
         rd.addr = hdr_index({1'b0, rd_id});
      end

      // Both fields written in one cycle always belong to the same header.
      wr = '0;
      wr.addr      = nx_go ? hdr_index({1'b0, nx_id}) : hdr_index(sz_id);
      wr.data.nxt  = nx_val;
      wr.data.size = sz_val;
      if (nx_go) begin
         if (nx_id == '0) begin
            sent_in = nx_val;
         end else begin
            wr.nxt_we = in_arena({1'b0, nx_id});
         end
      end
      if (sz_go) begin
         wr.size_we = in_arena(sz_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rover_ff     <= '0;
         sent_ff      <= '0;
         top_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         sent_ff      <= sent_in;
         top_ff       <= top_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      units_ff      <= units_in;
      bp_ff         <= bp_in;
      rid_ff        <= rid_in;
      prev_ff       <= prev_in;
      p_ff          <= p_in;
      tail_ff       <= tail_in;
      n_ff          <= n_in;
      psize_ff      <= psize_in;
      bsize_ff      <= bsize_in;
      bnsz_ff       <= bnsz_in;
      bnext_ff      <= bnext_in;
      acnt_ff       <= acnt_in;
      rcnt_ff       <= rcnt_in;
      grow_ff       <= grow_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FFA_ASSERT(a_top_bound, clock, reset, top_ff <= TOP_W'(ARENA_CHUNKS))
   `FFA_ASSERT_IMP(a_no_rw_clash, clock, reset, rd.en && (wr.nxt_we || wr.size_we), rd.addr != wr.addr)
   `FFA_ASSERT(a_one_at_a_time, clock, reset, (req_tvalid && req_tready) |=> !req_tready)
endmodule

[tb/sv/first_fit_free_list_allocator_test.sv]
`timescale 1ns / 1ps
module first_fit_free_list_allocator_test;
   import ffa_pkg::*;

   localparam int NODE_LIMIT = ARENA_CHUNKS;

   typedef struct {
      status_type  status;
      logic [7:0]  addr;
      logic [7:0]  free_chunks;
      logic [7:0]  claimed_chunks;
   } outcome_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [23:0]       req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [23:0]       rsp_tdata;
   logic [2:0]        rsp_tuser;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   first_fit_free_list_allocator dut (.*);

   // Shadow heap state.
   logic [15:0] hdr_next [NODE_LIMIT];
   logic [15:0] hdr_size [NODE_LIMIT];
   int unsigned heap_rover;
   int unsigned heap_head;
   bit          heap_listed;
   int unsigned heap_top;
   int unsigned heap_free;
   int unsigned heap_limit;

   outcome_type expected_outcomes[$];
   int unsigned live_blocks[$];
   int          failures;
   int          outcomes_seen;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit node_ok(int unsigned id);
      return id >= 1 && id <= NODE_LIMIT;
   endfunction

   function automatic int unsigned node_next(int unsigned id);
      if (id == 0) return heap_head;
      return node_ok(id) ? hdr_next[id-1] : 0;
   endfunction

   function automatic int unsigned node_size(int unsigned id);
      return node_ok(id) ? hdr_size[id-1] : 0;
   endfunction

   function automatic void put_next(int unsigned id, int unsigned v);
      if (id == 0) heap_head = v;
      else if (node_ok(id)) hdr_next[id-1] = 16'(v);
   endfunction

   function automatic void put_size(int unsigned id, int unsigned v);
      if (node_ok(id)) hdr_size[id-1] = 16'(v);
   endfunction

   function automatic void open_list();
      if (!heap_listed) begin
         heap_head   = 0;
         heap_rover  = 0;
         heap_listed = 1;
      end
   endfunction

   function automatic bit link_block(int unsigned bp);
      int unsigned sz, p, n;
      bit          hit;
      hit = 0;
      if (!node_ok(bp)) return 0;
      sz = node_size(bp);
      if (sz == 0 || sz > heap_top) return 0;
      open_list();
      p = heap_rover;
      for (int i = 0; i < NODE_LIMIT + 2; i++) begin
         n = node_next(p);
         if ((bp > p && bp < n) || (p >= n && (bp > p || bp < n))) begin
            hit = 1;
            break;
         end
         p = n;
      end
      if (!hit) return 0;
      n = node_next(p);
      if (bp + node_size(bp) == n) begin
         put_size(bp, node_size(bp) + node_size(n));
         put_next(bp, node_next(n));
      end else begin
         put_next(bp, n);
      end
      if (p + node_size(p) == bp) begin
         put_size(p, node_size(p) + node_size(bp));
         put_next(p, node_next(bp));
      end else begin
         put_next(p, bp);
      end
      heap_rover = p;
      heap_free += sz;
      return 1;
   endfunction

   function automatic bit extend_arena(int unsigned units);
      if (heap_top + units > NODE_LIMIT) return 0;
      put_size(heap_top + 1, units);
      heap_top += units;
      return link_block(heap_top - units + 1);
   endfunction

   function automatic int unsigned carve_block(int unsigned units);
      int unsigned prev, p, rest;
      open_list();
      prev = heap_rover;
      p = node_next(prev);
      for (int i = 0; i < 2 * (NODE_LIMIT + 2); i++) begin
         if (node_size(p) >= units) begin
            if (node_size(p) == units) begin
               put_next(prev, node_next(p));
            end else begin
               rest = node_size(p) - units;
               put_size(p, rest);
               p += rest;
               put_size(p, units);
            end
            heap_rover = prev;
            heap_free -= units;
            return p;
         end
         if (p == heap_rover) begin
            if (!extend_arena(units)) return 0;
            p = heap_rover;
         end
         prev = p;
         p = node_next(p);
      end
      return 0;
   endfunction

   function automatic outcome_type predict_outcome(logic kind, logic [15:0] bytes,
                                                   logic [7:0] where);
      outcome_type o;
      int unsigned units, got;
      got = 0;
      if (kind == REQ_ALLOC) begin
         units = (int'(bytes) + CHUNK_BYTES - 1) / CHUNK_BYTES + HEADER_CHUNKS;
         if (units + heap_top + heap_free > heap_limit) begin
            o.status = ST_LIMIT;
         end else begin
            got = carve_block(units);
            o.status = got != 0 ? ST_ALLOC : ST_LIMIT;
         end
      end else if (where == 0) begin
         o.status = ST_NULL;
      end else begin
         o.status = link_block(where) ? ST_FREED : ST_BADSIZE;
      end
      o.addr           = 8'(got);
      o.free_chunks    = 8'(heap_free);
      o.claimed_chunks = 8'(heap_top);
      return o;
   endfunction

   // The valid stays high between back-to-back items; it drops only while idling or draining.
   task automatic send_request(logic kind, logic [15:0] bytes, logic [7:0] where);
      outcome_type o;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {where, bytes};
      do @(posedge clock); while (!req_tready);
      o = predict_outcome(kind, bytes, where);
      expected_outcomes.push_back(o);
      if (o.status == ST_ALLOC) live_blocks.push_back(o.addr);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(REG_LIMIT);
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      heap_limit = value & 8'hff;
   endtask

   task automatic free_random_live();
      int k;
      int unsigned a;
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      send_request(REQ_FREE, 16'h0, 8'(a));
   endtask

   // Checker for every result item.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         outcome_type e;
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result item: status %0d", rsp_tuser);
            failures++;
         end else begin
            e = expected_outcomes.pop_front();
            outcomes_seen++;
            if (rsp_tuser !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[7:0] !== e.addr) begin
               $error("addr: expected %0d, got %0d", e.addr, rsp_tdata[7:0]);
               failures++;
            end
            if (rsp_tdata[15:8] !== e.free_chunks) begin
               $error("free_chunks: expected %0d, got %0d", e.free_chunks,
                      rsp_tdata[15:8]);
               failures++;
            end
            if (rsp_tdata[23:16] !== e.claimed_chunks) begin
               $error("claimed_chunks: expected %0d, got %0d", e.claimed_chunks,
                      rsp_tdata[23:16]);
               failures++;
            end
         end
      end
   end

   // The receiver may be held off completely for a counted stretch.
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   task automatic test_directed();
      send_request(REQ_FREE, 16'h0, 8'd0);
      send_request(REQ_FREE, 16'h0, 8'd200);
      send_request(REQ_FREE, 16'h0, 8'd5);
      send_request(REQ_ALLOC, 16'd0, 8'hff);
      send_request(REQ_ALLOC, 16'd1, 8'h0);
      send_request(REQ_ALLOC, 16'd16, 8'h0);
      send_request(REQ_ALLOC, 16'd17, 8'h0);
      send_request(REQ_ALLOC, 16'hffff, 8'h0);
      send_request(REQ_ALLOC, 16'd100, 8'h0);
      send_request(REQ_FREE, 16'hffff, 8'd2);
      send_request(REQ_FREE, 16'h0, 8'd2);
      send_request(REQ_FREE, 16'h0, 8'd1);
      send_request(REQ_FREE, 16'h0, 8'd3);
      send_request(REQ_FREE, 16'h0, 8'd5);
      send_request(REQ_ALLOC, 16'd32, 8'h0);
      send_request(REQ_FREE, 16'h0, 8'd128);
      send_request(REQ_FREE, 16'h0, 8'd129);
      send_request(REQ_FREE, 16'h0, 8'd255);
      live_blocks.delete();
   endtask

   task automatic test_random(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45) begin
            send_request(REQ_ALLOC, ($urandom_range(9) == 0) ? 16'($urandom) :
                         16'($urandom_range(200)), 8'($urandom));
         end else if (r < 85 && live_blocks.size() != 0) begin
            free_random_live();
         end else begin
            send_request(REQ_FREE, 16'($urandom), 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         test_random(20);
      join
   endtask

   initial begin
      clock = 1'b0;
      failures = 0; outcomes_seen = 0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
      for (int i = 0; i < NODE_LIMIT; i++) begin
         hdr_next[i] = '0;
         hdr_size[i] = '0;
      end
      heap_rover = 0; heap_head = 0; heap_listed = 0;
      heap_top = 0; heap_free = 0; heap_limit = 128;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(150);
      send_idle_pct = 49;
      test_random(150);
      write_limit(1);
      send_idle_pct = 0; recv_stall_pct = 49;
      test_random(40);
      write_limit(255);
      test_random(150);
      write_limit(40);
      send_idle_pct = 26; recv_stall_pct = 26;
      test_random(120);
      write_limit(128);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_backpressure();
      test_random(120);
      wait_drained();

      $display("Covered %0d results over allocations, frees, null and bad frees,",
               outcomes_seen);
      $display("limit settings 1 to 255, idling phases and a long output hold-off.");
      if (failures == 0 && expected_outcomes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

[files.f]
+incdir+design
design/ffa_pkg.sv
design/ffa_hdr_mem.sv
design/ffa_csr.sv
design/ffa_ctrl.sv
design/first_fit_free_list_allocator.sv
tb/sv/first_fit_free_list_allocator_test.sv
